FILE: rtl/pcpa_pkg.sv
// ----------------------------------------------------------------------------
// Per-CPU page allocator package
// Shared constants, payload types and controller/datapath interface types.
// ----------------------------------------------------------------------------
package pcpa_pkg;

	// Sizing. MAX_PAGES and NUM_CPUS are powers of two, so the slot and the
	// CPU index are the low bits of the frame number and of the cpu field.
	localparam int NUM_CPUS   = 8;
	localparam int MAX_PAGES  = 32768;
	localparam int PAGE_SHIFT = 12;

	localparam int ADDR_W = 32;
	localparam int PFN_W  = ADDR_W - PAGE_SHIFT;
	localparam int SLOT_W = $clog2(MAX_PAGES);
	localparam int CPU_W  = $clog2(NUM_CPUS);

	// Configuration registers.
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] CFG_MEM_LOW = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MEM_TOP = 1'd1;
	localparam logic [ADDR_W-1:0] MEM_LOW_RST = 32'h8000_0000;
	localparam logic [ADDR_W-1:0] MEM_TOP_RST = 32'h8800_0000;

	// Request kinds.
	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_OOM     = 2'd1,
		ST_BADFREE = 2'd2
	} status_t;

	typedef struct packed {
		logic        kind;
		logic [2:0]  cpu;
		logic [31:0] page_addr;
	} in_item_t;

	typedef struct packed {
		logic [31:0] alloc_addr;
		status_t     status;
	} out_item_t;

	// Which result the datapath loads into the output register.
	typedef enum logic [1:0] {
		RES_FREE_OK,
		RES_BAD,
		RES_OOM,
		RES_ALLOC
	} res_t;

	// Controller to datapath.
	typedef struct packed {
		logic capture;
		logic push;
		logic rd_issue;
		logic pop_wb;
		logic load_out;
		res_t res;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic is_free;
		logic bad_free;
		logic avail;
	} sts_t;

	// One entry of the next-link memory.
	typedef struct packed {
		logic             valid;
		logic [PFN_W-1:0] pfn;
	} link_t;

endpackage

FILE: rtl/pcpa_ctrl.sv
// ----------------------------------------------------------------------------
// Per-CPU page allocator controller
// Sequences one request at a time and owns the output valid flag.
// ----------------------------------------------------------------------------
module pcpa_ctrl import pcpa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_POP,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	res_t   res_q;
	res_t   res_n;
	logic   slot_free;
	logic   done;

	// The output register can take a result when empty or when its transfer
	// completes in this cycle.
	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Command decode per state.
	always_comb begin
		cmd   = '0;
		res_n = res_q;
		done  = 1'b0;
		case (state_q)
			S_IDLE: begin
				cmd.capture = in_valid;
			end
			S_EXEC: begin
				if (sts.is_free) begin
					cmd.push = !sts.bad_free;
					res_n    = sts.bad_free ? RES_BAD : RES_FREE_OK;
					done     = 1'b1;
				end else if (!sts.avail) begin
					res_n = RES_OOM;
					done  = 1'b1;
				end else begin
					cmd.rd_issue = 1'b1;
				end
			end
			S_POP: begin
				cmd.pop_wb = 1'b1;
				res_n      = RES_ALLOC;
				done       = 1'b1;
			end
			S_FINISH: begin
				done = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
		cmd.res      = res_n;
		cmd.load_out = done && slot_free;
	end

	// State, held result code and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			res_q       <= RES_FREE_OK;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC, S_POP, S_FINISH: begin
					if (done) begin
						res_q   <= res_n;
						state_q <= slot_free ? S_IDLE : S_FINISH;
					end else begin
						state_q <= S_POP;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/pcpa_datapath.sv
// ----------------------------------------------------------------------------
// Per-CPU page allocator datapath
// List heads, next-link memory, bounds check, donor select and result register.
// ----------------------------------------------------------------------------
module pcpa_datapath import pcpa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  in_item_t              in_data,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	output out_item_t             out_data
);

	logic [ADDR_W-1:0] mem_low_q;
	logic [ADDR_W-1:0] mem_top_q;
	in_item_t          item_q;

	logic [NUM_CPUS-1:0] head_valid_q;
	logic [PFN_W-1:0]    head_pfn_q [NUM_CPUS];

	link_t link_mem [MAX_PAGES];
	link_t rd_q;

	logic [CPU_W-1:0] donor_q;
	logic [PFN_W-1:0] top_q;
	out_item_t        out_q;

	logic [CPU_W-1:0]  own_cpu;
	logic [CPU_W-1:0]  first_cpu;
	logic [CPU_W-1:0]  donor;
	logic [CPU_W-1:0]  head_idx;
	logic [PFN_W-1:0]  head_rd;
	logic [PFN_W-1:0]  free_pfn;
	logic              bad_free;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_low_q <= MEM_LOW_RST;
			mem_top_q <= MEM_TOP_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_MEM_LOW) begin
				mem_low_q <= cfg_data;
			end
			if (cfg_index == CFG_MEM_TOP) begin
				mem_top_q <= cfg_data;
			end
		end
	end

	// Request register.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= in_data;
		end
	end

	// A free must be page aligned and inside the configured window.
	assign free_pfn = item_q.page_addr[ADDR_W-1:PAGE_SHIFT];
	assign bad_free = (item_q.page_addr[PAGE_SHIFT-1:0] != '0) ||
		(item_q.page_addr < mem_low_q) || (item_q.page_addr >= mem_top_q);

	// Donor select: the own list first, else the lowest non-empty list.
	assign own_cpu = item_q.cpu[CPU_W-1:0];
	always_comb begin
		first_cpu = '0;
		for (int i = NUM_CPUS - 1; i >= 0; i--) begin
			if (head_valid_q[i]) begin
				first_cpu = CPU_W'(i);
			end
		end
	end
	assign donor    = head_valid_q[own_cpu] ? own_cpu : first_cpu;
	assign head_idx = (item_q.kind == KIND_FREE) ? own_cpu : donor;
	assign head_rd  = head_pfn_q[head_idx];

	assign sts.is_free  = (item_q.kind == KIND_FREE);
	assign sts.bad_free = bad_free;
	assign sts.avail    = |head_valid_q;

	// Head valid flags: set on push, reloaded from the link on pop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= '0;
		end else if (cmd.push) begin
			head_valid_q[own_cpu] <= 1'b1;
		end else if (cmd.pop_wb) begin
			head_valid_q[donor_q] <= rd_q.valid;
		end
	end

	// Head frame numbers.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			head_pfn_q[own_cpu] <= free_pfn;
		end else if (cmd.pop_wb) begin
			head_pfn_q[donor_q] <= rd_q.pfn;
		end
	end

	// Next-link memory write: the pushed page links to the old head.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			link_mem[free_pfn[SLOT_W-1:0]] <= '{valid: head_valid_q[own_cpu], pfn: head_rd};
		end
	end

	// Next-link memory read of the donor's top page, with the pop context.
	always_ff @(posedge clk) begin
		if (cmd.rd_issue) begin
			rd_q    <= link_mem[head_rd[SLOT_W-1:0]];
			donor_q <= donor;
			top_q   <= head_rd;
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			case (cmd.res)
				RES_FREE_OK: begin
					out_q.alloc_addr <= '0;
					out_q.status     <= ST_OK;
				end
				RES_BAD: begin
					out_q.alloc_addr <= '0;
					out_q.status     <= ST_BADFREE;
				end
				RES_OOM: begin
					out_q.alloc_addr <= '0;
					out_q.status     <= ST_OOM;
				end
				RES_ALLOC: begin
					out_q.alloc_addr <= {top_q, {PAGE_SHIFT{1'b0}}};
					out_q.status     <= ST_OK;
				end
				default: begin
					out_q.alloc_addr <= '0;
					out_q.status     <= ST_OK;
				end
			endcase
		end
	end

	assign out_data = out_q;

endmodule

FILE: rtl/per_cpu_page_free_list_allocator.sv
// ----------------------------------------------------------------------------
// Per-CPU page free-list allocator
// Keeps a LIFO list of free pages per CPU; allocates with cross-CPU stealing.
// ----------------------------------------------------------------------------
// Usage:
//   A request enters on in_valid/in_ready as in_data (kind, cpu, page_addr).
//   A free (kind 1) pushes page_addr onto the list of its CPU after checking
//   that it is page aligned and lies in [mem_low, mem_top); a failed check
//   returns status bad-free and changes nothing. An allocate (kind 0) pops
//   the CPU's own list, else the lowest-numbered non-empty list, else returns
//   out-of-memory. Each request yields exactly one transfer on
//   out_valid/out_ready carrying alloc_addr and status.
//   One request is handled at a time. A free, and an allocate that finds every
//   list empty, are decided in the execute state; an allocate that pops a
//   page does a head lookup with a registered read of the next-link memory,
//   then the head write-back. The result register is loaded once it is free,
//   and the next request is accepted in the cycle after the result is loaded.
//   A stalled receiver holds the result in the output register; one further
//   request is still accepted and worked on, then waits for the register.
//   Reset empties every list and restores mem_low and mem_top; the link
//   memory is not cleared since entries are only read after being written.
//   The cfg_we/cfg_index/cfg_data port writes mem_low (0) or mem_top (1).
// ----------------------------------------------------------------------------
module per_cpu_page_free_list_allocator import pcpa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data
);

	cmd_t cmd;
	sts_t sts;

	// Sequencer.
	pcpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Lists, memory and result register.
	pcpa_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (out_data)
	);

	// After a request is taken the block is busy in the cycle after.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while previous one in progress");

	// Only a successful allocate carries a nonzero address.
	a_addr_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status != ST_OK) |-> out_data.alloc_addr == '0)
		else $error("nonzero address with error status");

	// A new result only appears while a request is being worked on.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result produced without a pending request");

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// Testbench for the per-CPU page free-list allocator
// Sends allocate and free requests with random gaps on both handshakes and
// predicts every reply with a behavioral copy of the per-CPU lists. Each reply
// is compared field by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module tb_top;
	import pcpa_pkg::*;

	localparam logic [ADDR_W-1:0] PAGE_MASK = (32'd1 << PAGE_SHIFT) - 1;
	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 2000;

	// Behavioral copy of the allocator, plus the queue of predicted replies.
	class page_list_scoreboard;
		bit [ADDR_W-1:0] low_bound;
		bit [ADDR_W-1:0] top_bound;
		bit head_ok[NUM_CPUS];
		bit [PFN_W-1:0] head_pfn[NUM_CPUS];
		bit link_ok[MAX_PAGES];
		bit [PFN_W-1:0] link_pfn[MAX_PAGES];
		int listed[bit [PFN_W-1:0]];
		out_item_t pending_results[$];
		int errors;
		int grants;
		int steals;
		int oom_count;
		int frees_ok;
		int bad_frees;

		function new();
			low_bound = MEM_LOW_RST;
			top_bound = MEM_TOP_RST;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			if (idx == CFG_MEM_LOW) begin
				low_bound = val;
			end else begin
				top_bound = val;
			end
		endfunction

		// Pops the top page of one CPU's list; returns 0 when the list is empty.
		function bit take_page(int c, output bit [PFN_W-1:0] pfn);
			bit [SLOT_W-1:0] s;
			pfn = '0;
			if (!head_ok[c]) return 1'b0;
			pfn = head_pfn[c];
			s = pfn[SLOT_W-1:0];
			head_ok[c] = link_ok[s];
			head_pfn[c] = link_pfn[s];
			if (listed.exists(pfn) && listed[pfn] > 0) listed[pfn]--;
			return 1'b1;
		endfunction

		function bit is_listed(bit [PFN_W-1:0] pfn);
			return listed.exists(pfn) && listed[pfn] > 0;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		// Applies one accepted request and queues the reply it must produce.
		function void note_request(in_item_t req);
			out_item_t exp_res;
			bit [PFN_W-1:0] pfn;
			bit [SLOT_W-1:0] s;
			bit got;
			int c;
			c = int'(req.cpu) % NUM_CPUS;
			exp_res.alloc_addr = '0;
			exp_res.status = ST_OK;
			if (req.kind == KIND_FREE) begin
				if (req.page_addr[PAGE_SHIFT-1:0] != 0 || req.page_addr < low_bound ||
						req.page_addr >= top_bound) begin
					exp_res.status = ST_BADFREE;
					bad_frees++;
				end else begin
					// Push: the page's link slot takes the old head.
					pfn = req.page_addr[ADDR_W-1:PAGE_SHIFT];
					s = pfn[SLOT_W-1:0];
					link_ok[s] = head_ok[c];
					link_pfn[s] = head_pfn[c];
					head_ok[c] = 1'b1;
					head_pfn[c] = pfn;
					listed[pfn] = listed.exists(pfn) ? listed[pfn] + 1 : 1;
					frees_ok++;
				end
			end else begin
				// Own list first, then the lowest-numbered other CPU with pages.
				got = take_page(c, pfn);
				for (int i = 0; i < NUM_CPUS && !got; i++) begin
					if (i != c) begin
						got = take_page(i, pfn);
						if (got) steals++;
					end
				end
				if (got) begin
					exp_res.alloc_addr = {pfn, {PAGE_SHIFT{1'b0}}};
					grants++;
				end else begin
					exp_res.status = ST_OOM;
					oom_count++;
				end
			end
			pending_results.push_back(exp_res);
		endfunction

		// Compares one reply transfer with the oldest prediction.
		function void check_result(out_item_t got_res);
			out_item_t exp_res;
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("ERROR: reply with none predicted: addr %h status %0d",
						got_res.alloc_addr, got_res.status);
				return;
			end
			exp_res = pending_results.pop_front();
			if (got_res.alloc_addr !== exp_res.alloc_addr || got_res.status !== exp_res.status) begin
				errors++;
				if (errors <= 10)
					$display("ERROR: reply mismatch: expected addr %h status %0d, got addr %h status %0d",
						exp_res.alloc_addr, exp_res.status, got_res.alloc_addr, got_res.status);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;

	page_list_scoreboard sb = new();
	int send_calm = 0;
	int recv_calm = 0;
	bit hold_off_request = 1'b0;
	int quiet_cycles = 0;
	int items_sent = 0;
	int reg_writes = 0;

	per_cpu_page_free_list_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Watchdog: ends the run when no transfer happens for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Wait before the next transfer; now and then a calm stretch with no gaps.
	function automatic int draw_wait(ref int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) calm = $urandom_range(8, 40);
		return $urandom_range(0, 10);
	endfunction

	function automatic in_item_t request_of(logic kind, int cpu, logic [ADDR_W-1:0] addr);
		in_item_t req;
		req.kind = kind;
		req.cpu = cpu[2:0];
		req.page_addr = addr;
		return req;
	endfunction

	// Random request: mostly allocates and in-window frees, some malformed frees.
	function automatic in_item_t make_request(int free_pct, bit allow_repeat);
		in_item_t req;
		longint unsigned first_pfn;
		longint unsigned last_pfn;
		longint unsigned span;
		longint unsigned pfn;
		bit has_window;
		bit usable;
		int pick;
		req.kind = KIND_ALLOC;
		req.cpu = 3'($urandom_range(0, 7));
		req.page_addr = $urandom;
		pick = $urandom_range(0, 99);
		if (pick >= free_pct) return req;
		req.kind = KIND_FREE;
		first_pfn = (64'(sb.low_bound) + 64'(PAGE_MASK)) >> PAGE_SHIFT;
		last_pfn = (64'(sb.top_bound) - 64'd1) >> PAGE_SHIFT;
		has_window = sb.top_bound != 0 && first_pfn <= last_pfn;
		if (!has_window || pick >= free_pct * 7 / 8) begin
			case ($urandom_range(0, 3))
				1: req.page_addr = sb.top_bound & ~PAGE_MASK;
				2: req.page_addr = sb.low_bound | 32'($urandom_range(1, PAGE_MASK));
				3: req.page_addr = (sb.low_bound & ~PAGE_MASK) - (32'd1 << PAGE_SHIFT);
				default: ;
			endcase
			return req;
		end
		span = last_pfn - first_pfn + 64'd1;
		usable = 1'b0;
		pfn = first_pfn;
		for (int tries = 0; tries < 4 && !usable; tries++) begin
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				pfn = first_pfn;
			end else if (pick == 1) begin
				pfn = last_pfn;
			end else if (pick < 6) begin
				// Small pool with aliases one link-memory size apart.
				pfn = first_pfn + 64'($urandom_range(0, 31)) +
					64'($urandom_range(0, 3)) * 64'(MAX_PAGES);
				if (pfn > last_pfn) pfn = first_pfn + (pfn - first_pfn) % span;
			end else begin
				pfn = first_pfn + {$urandom, $urandom} % span;
			end
			usable = allow_repeat || !sb.is_listed(pfn[PFN_W-1:0]);
		end
		if (!usable) begin
			req.kind = KIND_ALLOC;
			return req;
		end
		req.page_addr = {pfn[PFN_W-1:0], {PAGE_SHIFT{1'b0}}};
		return req;
	endfunction

	task automatic send_request(in_item_t req);
		int gap;
		gap = draw_wait(send_calm);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		do @(posedge clk); while (in_ready !== 1'b1);
		sb.note_request(req);
		items_sent++;
	endtask

	// Pauses the sender until every predicted reply has been transferred.
	task automatic wait_for_replies();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_register(idx, val);
		reg_writes++;
	endtask

	task automatic set_window(logic [ADDR_W-1:0] low, logic [ADDR_W-1:0] top);
		write_register(CFG_MEM_LOW, low);
		write_register(CFG_MEM_TOP, top);
	endtask

	task automatic run_random(int count, int free_pct, bit allow_repeat);
		repeat (count) send_request(make_request(free_pct, allow_repeat));
	endtask

	// Reply side: random stalls, and one long hold-off when asked.
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_off_request) begin
				stall = HOLD_CYCLES;
				hold_off_request = 1'b0;
			end else begin
				stall = draw_wait(recv_calm);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			sb.check_result(out_data);
		end
	end

	initial begin
		wait (arst_n === 1'b1);

		// Directed requests under the reset bounds.
		send_request(request_of(KIND_ALLOC, 0, 32'hFFFF_FFFF));   // every list empty
		send_request(request_of(KIND_FREE, 3, 32'h8000_0000));    // lowest legal page
		send_request(request_of(KIND_FREE, 7, 32'h87FF_F000));    // highest legal page
		send_request(request_of(KIND_FREE, 1, 32'h8800_0000));    // at the top bound
		send_request(request_of(KIND_FREE, 2, 32'h7FFF_F000));    // below the low bound
		send_request(request_of(KIND_FREE, 4, 32'h8000_0800));    // not page aligned
		send_request(request_of(KIND_FREE, 6, 32'hFFFF_FFFF));
		send_request(request_of(KIND_ALLOC, 5, 32'h0));           // taken from CPU 3
		send_request(request_of(KIND_ALLOC, 5, 32'h0));           // taken from CPU 7
		send_request(request_of(KIND_ALLOC, 7, 32'h0));
		send_request(request_of(KIND_FREE, 0, 32'h8000_5000));
		send_request(request_of(KIND_FREE, 1, 32'h8000_5000));    // same page freed twice
		send_request(request_of(KIND_ALLOC, 0, 32'h0));
		send_request(request_of(KIND_ALLOC, 1, 32'h0));
		wait_for_replies();

		// Directed requests with the widest bounds.
		set_window(32'h0000_0000, 32'hFFFF_FFFF);
		send_request(request_of(KIND_FREE, 2, 32'h0000_0000));    // page at address zero
		send_request(request_of(KIND_ALLOC, 2, 32'h0));
		send_request(request_of(KIND_FREE, 4, 32'h0000_3000));
		send_request(request_of(KIND_FREE, 4, 32'h0000_3000));    // list loops on itself
		send_request(request_of(KIND_FREE, 5, 32'h0800_3000));    // shares the link slot
		send_request(request_of(KIND_ALLOC, 4, 32'h0));
		send_request(request_of(KIND_ALLOC, 4, 32'h0));
		send_request(request_of(KIND_FREE, 7, 32'hFFFF_F000));
		send_request(request_of(KIND_ALLOC, 7, 32'hFFFF_FFFF));
		wait_for_replies();

		// Reset bounds again, with one long hold-off on the reply side.
		set_window(MEM_LOW_RST, MEM_TOP_RST);
		run_random(60, 50, 1'b0);
		send_calm = 120;
		hold_off_request = 1'b1;
		run_random(240, 50, 1'b0);
		wait_for_replies();

		// Window twice the link memory, so slots alias.
		set_window(32'h0000_0000, 32'h1000_0000);
		run_random(250, 50, 1'b0);
		wait_for_replies();

		// A narrow window with unaligned bounds.
		set_window(32'h4000_0801, 32'h4001_0800);
		run_random(150, 55, 1'b0);
		wait_for_replies();

		// Every free is rejected; the lists drain to empty.
		set_window(32'hFFFF_FFFF, 32'h0000_0000);
		run_random(80, 30, 1'b0);
		wait_for_replies();

		// Full range with repeated frees allowed.
		set_window(32'h0000_0000, 32'hFFFF_FFFF);
		run_random(170, 50, 1'b1);
		wait_for_replies();

		repeat (16) @(posedge clk);
		$display("Run covered %0d requests and %0d register writes.", items_sent, reg_writes);
		$display("Grants %0d (%0d from another CPU), out of memory %0d, frees %0d, rejected %0d.",
			sb.grants, sb.steals, sb.oom_count, sb.frees_ok, sb.bad_frees);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule

FILE: files.f
rtl/pcpa_pkg.sv
rtl/pcpa_ctrl.sv
rtl/pcpa_datapath.sv
rtl/per_cpu_page_free_list_allocator.sv
bench/tb_top.sv
